### sv/deadline_ordered_alarm_queue_macros.svh
// assertion macros for the deadline ordered alarm queue
`ifndef DEADLINE_ORDERED_ALARM_QUEUE_MACROS_SVH
`define DEADLINE_ORDERED_ALARM_QUEUE_MACROS_SVH

// same-cycle implication, checked out of reset
`define DOAQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define DOAQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### sv/doaq_pkg.sv
// shared constants, types and helpers of the deadline ordered alarm queue
package doaq_pkg;

  localparam int DEPTH       = 16;
  localparam int TIME_BITS   = 32;
  localparam int MAX_RESULTS = 16;
  localparam int DELAY_W     = 16;
  localparam int TAG_W       = 16;

  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int NRES_W = $clog2(MAX_RESULTS + 1);

  // input commands
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  // result kinds
  localparam logic [1:0] KIND_ACCEPT = 2'd0;
  localparam logic [1:0] KIND_REJECT = 2'd1;
  localparam logic [1:0] KIND_FIRED  = 2'd2;

  // one stored alarm
  typedef struct packed {
    logic [TIME_BITS-1:0] deadline;
    logic [DELAY_W-1:0]   delay;
    logic [TAG_W-1:0]     tag;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // request to the shared add / subtract unit
  typedef struct packed {
    logic [TIME_BITS-1:0] a;
    logic [TIME_BITS-1:0] b;
    logic                 sub;
  } doaq_alu_req_t;

  // physical ram slot of a queue position, ring buffer starting at head
  function automatic logic [IDX_W-1:0] wrap_idx(input logic [IDX_W-1:0] head,
                                                input logic [CNT_W-1:0] lg);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(head) + (CNT_W+1)'(lg);
    if (s >= (CNT_W+1)'(DEPTH)) begin
      s = s - (CNT_W+1)'(DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

endpackage

### sv/doaq_ram.sv
// generic single-port-write, single-port-read ram with registered read data
module doaq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic                                     rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### sv/doaq_alu.sv
// shared add / subtract unit for deadline sums and wrapped time compares
module doaq_alu
  import doaq_pkg::*;
(
  input  doaq_alu_req_t        req,
  output logic [TIME_BITS-1:0] sum
);

  // a + b, or a - b in two's complement
  assign sum = req.a + (req.sub ? ~req.b : req.b) + TIME_BITS'(req.sub);

endmodule

### sv/deadline_ordered_alarm_queue.sv
// Deadline ordered alarm queue: DEPTH pending alarms kept sorted by deadline in a ring-buffer
// ram, worked by one add/subtract unit under a small sequencer. An insert reads and compares
// stored alarms from the head until it finds its position, then moves the tail up one slot with
// a read and a write per alarm, all through the ram and the single compare unit, writes the new
// alarm and emits one result; a full queue rejects without a scan. A tick reads and compares the
// head alarm and fires it while it is due (at most MAX_RESULTS), and waits while the result side stalls.
// in_stall is high for the whole of that work; a finished result waits in the output register
// while the next item is accepted. No clearing pass follows reset.
`include "deadline_ordered_alarm_queue_macros.svh"

module deadline_ordered_alarm_queue
  import doaq_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_command,
  input  logic [DELAY_W-1:0] in_delay_seconds,
  input  logic [TAG_W-1:0]   in_message_tag,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_result_kind,
  output logic [DELAY_W-1:0] out_fired_seconds,
  output logic [TAG_W-1:0]   out_fired_tag,
  output logic               out_last
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SCAN_RD  = 4'd1;
  localparam logic [3:0] S_SCAN_CMP = 4'd2;
  localparam logic [3:0] S_SH_RD    = 4'd3;
  localparam logic [3:0] S_SH_WR    = 4'd4;
  localparam logic [3:0] S_PUT      = 4'd5;
  localparam logic [3:0] S_EMIT     = 4'd6;
  localparam logic [3:0] S_FIRE_RD  = 4'd7;
  localparam logic [3:0] S_FIRE_CMP = 4'd8;
  localparam logic [3:0] S_FIRE_END = 4'd9;

  logic [3:0]           state_r, state_nxt;
  logic [TIME_BITS-1:0] now_r, now_nxt;
  logic [IDX_W-1:0]     head_r, head_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [CNT_W-1:0]     pos_r, pos_nxt;
  logic [CNT_W-1:0]     idx_r, idx_nxt;
  logic [NRES_W-1:0]    nfire_r, nfire_nxt;
  entry_t               new_r, new_nxt;
  logic [1:0]           kind_r, kind_nxt;
  logic [DELAY_W-1:0]   hold_delay_r, hold_delay_nxt;
  logic [TAG_W-1:0]     hold_tag_r, hold_tag_nxt;
  logic                 hold_v_r, hold_v_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [1:0]           out_kind_r, out_kind_nxt;
  logic [DELAY_W-1:0]   out_secs_r, out_secs_nxt;
  logic [TAG_W-1:0]     out_tag_r, out_tag_nxt;
  logic                 out_last_r, out_last_nxt;

  doaq_alu_req_t        alu_req;
  logic [TIME_BITS-1:0] alu_sum;

  logic                 ram_wr_en, ram_rd_en;
  logic [IDX_W-1:0]     ram_wr_addr, ram_rd_addr;
  entry_t               ram_wr_data, ram_rd_data;

  logic                 in_take, out_free, is_before, is_due;

  doaq_alu u_alu (
    .req (alu_req),
    .sum (alu_sum)
  );

  doaq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // handshake
  assign in_stall = (state_r != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // wrapped compares from the shared unit
  assign is_before = alu_sum[TIME_BITS-1];
  assign is_due    = !alu_sum[TIME_BITS-1];

  // shared unit operand select
  always_comb begin
    alu_req.a   = now_r;
    alu_req.b   = TIME_BITS'(1);
    alu_req.sub = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_command == CMD_INSERT) begin
          alu_req.b = TIME_BITS'(in_delay_seconds);
        end
      end
      S_SCAN_CMP: begin
        alu_req.a   = ram_rd_data.deadline;
        alu_req.b   = new_r.deadline;
        alu_req.sub = 1'b1;
      end
      S_FIRE_CMP: begin
        alu_req.b   = ram_rd_data.deadline;
        alu_req.sub = 1'b1;
      end
      default: begin
        alu_req.sub = 1'b0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    now_nxt        = now_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    pos_nxt        = pos_r;
    idx_nxt        = idx_r;
    nfire_nxt      = nfire_r;
    new_nxt        = new_r;
    kind_nxt       = kind_r;
    hold_delay_nxt = hold_delay_r;
    hold_tag_nxt   = hold_tag_r;
    hold_v_nxt     = hold_v_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_kind_nxt   = out_kind_r;
    out_secs_nxt   = out_secs_r;
    out_tag_nxt    = out_tag_r;
    out_last_nxt   = out_last_r;
    ram_wr_en      = 1'b0;
    ram_wr_addr    = wrap_idx(head_r, idx_r);
    ram_wr_data    = ram_rd_data;
    ram_rd_en      = 1'b0;
    ram_rd_addr    = wrap_idx(head_r, pos_r);

    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          if (in_command == CMD_TICK) begin
            now_nxt    = alu_sum;
            nfire_nxt  = '0;
            hold_v_nxt = 1'b0;
            state_nxt  = S_FIRE_RD;
          end else begin
            new_nxt.delay = in_delay_seconds;
            new_nxt.tag   = in_message_tag;
            if (count_r == CNT_W'(DEPTH)) begin
              kind_nxt  = KIND_REJECT;
              state_nxt = S_EMIT;
            end else begin
              new_nxt.deadline = alu_sum;
              pos_nxt          = '0;
              state_nxt        = S_SCAN_RD;
            end
          end
        end
      end
      // look for the first alarm not earlier than the new one
      S_SCAN_RD: begin
        if (pos_r == count_r) begin
          idx_nxt   = count_r;
          state_nxt = S_SH_RD;
        end else begin
          ram_rd_en = 1'b1;
          state_nxt = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if (is_before) begin
          pos_nxt   = pos_r + CNT_W'(1);
          state_nxt = S_SCAN_RD;
        end else begin
          idx_nxt   = count_r;
          state_nxt = S_SH_RD;
        end
      end
      // open a gap at pos, moving the tail up one slot
      S_SH_RD: begin
        if (idx_r == pos_r) begin
          state_nxt = S_PUT;
        end else begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = wrap_idx(head_r, idx_r - CNT_W'(1));
          state_nxt   = S_SH_WR;
        end
      end
      S_SH_WR: begin
        ram_wr_en = 1'b1;
        idx_nxt   = idx_r - CNT_W'(1);
        state_nxt = S_SH_RD;
      end
      S_PUT: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = wrap_idx(head_r, pos_r);
        ram_wr_data = new_r;
        count_nxt   = count_r + CNT_W'(1);
        kind_nxt    = KIND_ACCEPT;
        state_nxt   = S_EMIT;
      end
      // single result of an insert
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = kind_r;
          out_secs_nxt  = new_r.delay;
          out_tag_nxt   = new_r.tag;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      // read the head alarm while room remains in this tick
      S_FIRE_RD: begin
        if ((count_r != '0) && (nfire_r != NRES_W'(MAX_RESULTS))) begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = head_r;
          state_nxt   = S_FIRE_CMP;
        end else begin
          state_nxt = S_FIRE_END;
        end
      end
      // a due head is held back one step so the final one can carry last
      S_FIRE_CMP: begin
        if (is_due) begin
          if (!hold_v_r || out_free) begin
            if (hold_v_r) begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = KIND_FIRED;
              out_secs_nxt  = hold_delay_r;
              out_tag_nxt   = hold_tag_r;
              out_last_nxt  = 1'b0;
            end
            hold_delay_nxt = ram_rd_data.delay;
            hold_tag_nxt   = ram_rd_data.tag;
            hold_v_nxt     = 1'b1;
            head_nxt       = wrap_idx(head_r, CNT_W'(1));
            count_nxt      = count_r - CNT_W'(1);
            nfire_nxt      = nfire_r + NRES_W'(1);
            state_nxt      = S_FIRE_RD;
          end
        end else begin
          state_nxt = S_FIRE_END;
        end
      end
      S_FIRE_END: begin
        if (!hold_v_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_FIRED;
          out_secs_nxt  = hold_delay_r;
          out_tag_nxt   = hold_tag_r;
          out_last_nxt  = 1'b1;
          hold_v_nxt    = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      now_r       <= '0;
      head_r      <= '0;
      count_r     <= '0;
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      now_r       <= now_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      hold_v_r    <= hold_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working and payload registers
  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    idx_r        <= idx_nxt;
    nfire_r      <= nfire_nxt;
    new_r        <= new_nxt;
    kind_r       <= kind_nxt;
    hold_delay_r <= hold_delay_nxt;
    hold_tag_r   <= hold_tag_nxt;
    out_kind_r   <= out_kind_nxt;
    out_secs_r   <= out_secs_nxt;
    out_tag_r    <= out_tag_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_result_kind   = out_kind_r;
  assign out_fired_seconds = out_secs_r;
  assign out_fired_tag     = out_tag_r;
  assign out_last          = out_last_r;

  // checks
  `DOAQ_ASSERT_IMPL(a_count_in_range, 1'b1, count_r <= CNT_W'(DEPTH), "alarm count above depth")
  `DOAQ_ASSERT_IMPL(a_hold_in_tick, hold_v_r,
                    (state_r == S_FIRE_RD) || (state_r == S_FIRE_CMP) || (state_r == S_FIRE_END),
                    "held alarm outside a tick")
  `DOAQ_ASSERT_NEXT(a_tick_advances, in_take && (in_command == CMD_TICK),
                    now_r == $past(now_r) + TIME_BITS'(1), "tick did not advance time")

endmodule

### sim/alarm_result_checker.sv
// result checker for the deadline ordered alarm queue: predicts results and compares them
module alarm_result_checker
  import doaq_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               in_command,
  input  logic [DELAY_W-1:0] in_delay_seconds,
  input  logic [TAG_W-1:0]   in_message_tag,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [1:0]         out_result_kind,
  input  logic [DELAY_W-1:0] out_fired_seconds,
  input  logic [TAG_W-1:0]   out_fired_tag,
  input  logic               out_last,
  input  logic               drain_done,
  output int                 mismatches,
  output int                 pending,
  output int                 fired_seen,
  output int                 rejected_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  // one result item as the block should emit it
  typedef struct packed {
    logic [1:0]         kind;
    logic [DELAY_W-1:0] secs;
    logic [TAG_W-1:0]   tag;
    logic               last;
  } alarm_result_t;

  alarm_result_t        expected_results[$];
  logic [TIME_BITS-1:0] model_now;
  entry_t               model_alarms[DEPTH];
  int                   model_fill;

  // a is strictly earlier than b when the wrapped difference has its top bit set
  function automatic bit deadline_earlier(input logic [TIME_BITS-1:0] a,
                                          input logic [TIME_BITS-1:0] b);
    logic [TIME_BITS-1:0] diff;
    diff = a - b;
    return diff[TIME_BITS-1];
  endfunction

  function automatic void push_expected(input logic [1:0] kind,
                                        input logic [DELAY_W-1:0] secs,
                                        input logic [TAG_W-1:0] tag,
                                        input logic last);
    alarm_result_t r;
    r.kind = kind;
    r.secs = secs;
    r.tag  = tag;
    r.last = last;
    expected_results.push_back(r);
  endfunction

  // apply one item to the predicted queue and queue up the results it causes
  function automatic void predict_alarm_item(input logic cmd,
                                             input logic [DELAY_W-1:0] dly,
                                             input logic [TAG_W-1:0] tg);
    logic [TIME_BITS-1:0] dl;
    int pos;
    int due;
    int i;
    if (cmd == CMD_INSERT) begin
      if (model_fill >= DEPTH) begin
        push_expected(KIND_REJECT, dly, tg, 1'b1);
      end else begin
        dl = model_now + TIME_BITS'(dly);
        // new alarm goes ahead of stored alarms with an equal deadline
        pos = 0;
        while (pos < model_fill && deadline_earlier(model_alarms[pos].deadline, dl)) begin
          pos++;
        end
        for (i = model_fill; i > pos; i--) begin
          model_alarms[i] = model_alarms[i-1];
        end
        model_alarms[pos].deadline = dl;
        model_alarms[pos].delay    = dly;
        model_alarms[pos].tag      = tg;
        model_fill++;
        push_expected(KIND_ACCEPT, dly, tg, 1'b1);
      end
    end else begin
      model_now = model_now + 1'b1;
      // count the due alarms at the head first so the last one can be marked
      due = 0;
      while (due < model_fill && due < MAX_RESULTS &&
             !deadline_earlier(model_now, model_alarms[due].deadline)) begin
        due++;
      end
      for (i = 0; i < due; i++) begin
        push_expected(KIND_FIRED, model_alarms[i].delay, model_alarms[i].tag, i == due - 1);
      end
      for (i = due; i < model_fill; i++) begin
        model_alarms[i-due] = model_alarms[i];
      end
      model_fill -= due;
    end
  endfunction

  // compare one result item against the oldest prediction
  function automatic void check_alarm_result();
    alarm_result_t want;
    if (expected_results.size() == 0) begin
      $error("unexpected result: result_kind %0d fired_seconds %0d fired_tag %0d last %0d",
             out_result_kind, out_fired_seconds, out_fired_tag, out_last);
      mismatches++;
    end else begin
      want = expected_results.pop_front();
      if (out_result_kind !== want.kind) begin
        $error("result_kind: expected %0d, actual %0d", want.kind, out_result_kind);
        mismatches++;
      end
      if (out_fired_seconds !== want.secs) begin
        $error("fired_seconds: expected %0d, actual %0d", want.secs, out_fired_seconds);
        mismatches++;
      end
      if (out_fired_tag !== want.tag) begin
        $error("fired_tag: expected %0d, actual %0d", want.tag, out_fired_tag);
        mismatches++;
      end
      if (out_last !== want.last) begin
        $error("last: expected %0d, actual %0d", want.last, out_last);
        mismatches++;
      end
    end
    if (out_result_kind == KIND_FIRED) fired_seen++;
    if (out_result_kind == KIND_REJECT) rejected_seen++;
  endfunction

  initial begin
    mismatches    = 0;
    fired_seen    = 0;
    rejected_seen = 0;
    pending       = 0;
  end

  // results first, so a result at the same edge as an item matches older work
  always @(posedge clk) begin
    if (!rst_n) begin
      model_now  = '0;
      model_fill = 0;
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) check_alarm_result();
      if (in_valid && !in_stall) predict_alarm_item(in_command, in_delay_seconds, in_message_tag);
    end
    pending <= expected_results.size();
  end

  // predictions still waiting once the run has drained
  always @(posedge drain_done) begin
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      mismatches += expected_results.size();
    end
  end

endmodule

### sim/tb_deadline_ordered_alarm_queue.sv
// testbench top for the deadline ordered alarm queue: stimulus, idling and verdict
module tb_deadline_ordered_alarm_queue
  import doaq_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS   = 400;
  localparam int HOLD_AT_ITEM   = 120;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 80;
  localparam int WATCHDOG_LIMIT = 4000;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic               in_command;
  logic [DELAY_W-1:0] in_delay_seconds;
  logic [TAG_W-1:0]   in_message_tag;
  logic               out_valid;
  logic               out_stall;
  logic [1:0]         out_result_kind;
  logic [DELAY_W-1:0] out_fired_seconds;
  logic [TAG_W-1:0]   out_fired_tag;
  logic               out_last;
  logic               drain_done;

  int mismatches;
  int pending;
  int fired_seen;
  int rejected_seen;
  int items_sent    = 0;
  int inserts_sent  = 0;
  int ticks_sent    = 0;
  int long_budget   = 3;
  int idle_cycles   = 0;

  always #4 clk = ~clk;

  deadline_ordered_alarm_queue dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_delay_seconds  (in_delay_seconds),
    .in_message_tag    (in_message_tag),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_result_kind   (out_result_kind),
    .out_fired_seconds (out_fired_seconds),
    .out_fired_tag     (out_fired_tag),
    .out_last          (out_last)
  );

  alarm_result_checker alarm_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_delay_seconds  (in_delay_seconds),
    .in_message_tag    (in_message_tag),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_result_kind   (out_result_kind),
    .out_fired_seconds (out_fired_seconds),
    .out_fired_tag     (out_fired_tag),
    .out_last          (out_last),
    .drain_done        (drain_done),
    .mismatches        (mismatches),
    .pending           (pending),
    .fired_seen        (fired_seen),
    .rejected_seen     (rejected_seen)
  );

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // short delays keep alarms firing; a few far ones stay parked in the queue
  function automatic logic [DELAY_W-1:0] pick_delay();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return DELAY_W'($urandom_range(0, 6));
    if (r < 95) return DELAY_W'($urandom_range(7, 30));
    if (r < 98) return DELAY_W'($urandom_range(31, 120));
    if (long_budget > 0) begin
      long_budget--;
      return DELAY_W'($urandom_range(121, 65535));
    end
    return DELAY_W'($urandom_range(0, 6));
  endfunction

  // offer one item after an optional gap and hold it until accepted
  task automatic offer_item(input logic cmd, input logic [DELAY_W-1:0] dly,
                            input logic [TAG_W-1:0] tg, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_command       <= cmd;
    in_delay_seconds <= dly;
    in_message_tag   <= tg;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (cmd == CMD_INSERT) inserts_sent++;
    else ticks_sent++;
  endtask

  // cycles with no item moving on either side
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
    $display("tb_deadline_ordered_alarm_queue failed");
    $finish;
  end

  // result side: random stalls, one long hold-off while items keep coming
  initial begin
    int open_len;
    int gap;
    int hold_cnt;
    bit hold_done;
    hold_done = 1'b0;
    forever begin
      if (!hold_done && items_sent >= HOLD_AT_ITEM) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++) @(posedge clk);
      end else begin
        open_len = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 8)
                                                 : $urandom_range(20, 120);
        out_stall <= 1'b0;
        repeat (open_len) @(posedge clk);
        gap = pick_gap();
        if (gap > 0) begin
          out_stall <= 1'b1;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  // stimulus and verdict
  initial begin
    int i;
    int k;
    int burst;
    int mode;
    int random_items;
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_command       <= CMD_INSERT;
    in_delay_seconds <= '0;
    in_message_tag   <= '0;
    drain_done       <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // tick on an empty queue fires nothing
    offer_item(CMD_TICK, '0, '0, pick_gap());
    // fill the queue with equal deadlines in two groups, interleaved
    for (i = 0; i < DEPTH; i++) begin
      offer_item(CMD_INSERT, DELAY_W'(i % 2),
                 (i % 2) ? TAG_W'(16'hFFFF - i) : TAG_W'(i), pick_gap());
    end
    // full queue refuses
    offer_item(CMD_INSERT, 16'hFFFF, 16'hFFFF, pick_gap());
    // every stored alarm due at once
    offer_item(CMD_TICK, '0, '0, pick_gap());
    // farthest deadline, then one that fires after three ticks
    offer_item(CMD_INSERT, 16'hFFFF, 16'h0000, pick_gap());
    offer_item(CMD_INSERT, 16'd3, 16'hFFFF, pick_gap());
    for (i = 0; i < 3; i++) begin
      offer_item(CMD_TICK, 16'hFFFF, 16'hFFFF, pick_gap());
    end

    // random part: insert bursts to fill up, tick bursts to drain, single mixed items
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      mode = $urandom_range(0, 9);
      if (mode == 0) begin
        burst = $urandom_range(8, 20);
        for (k = 0; k < burst; k++) begin
          offer_item(CMD_INSERT, pick_delay(), TAG_W'($urandom), 0);
          random_items++;
        end
      end else if (mode == 1) begin
        burst = $urandom_range(3, 12);
        for (k = 0; k < burst; k++) begin
          offer_item(CMD_TICK, DELAY_W'($urandom), TAG_W'($urandom), pick_gap());
          random_items++;
        end
      end else begin
        offer_item($urandom_range(0, 1) ? CMD_TICK : CMD_INSERT, pick_delay(),
                   TAG_W'($urandom), pick_gap());
        random_items++;
      end
    end
    in_valid <= 1'b0;

    // drain, then let a result-free tick or a slow insert finish
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    drain_done <= 1'b1;
    repeat (2) @(posedge clk);

    $display("run: %0d items (%0d inserts, %0d ticks)", items_sent, inserts_sent, ticks_sent);
    $display("run: %0d alarms fired, %0d inserts refused on a full queue",
             fired_seen, rejected_seen);
    if (mismatches == 0) begin
      $display("tb_deadline_ordered_alarm_queue passed");
    end else begin
      $display("tb_deadline_ordered_alarm_queue failed");
    end
    $finish;
  end

endmodule
